FILE: rtl/mini_arm_execute_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef MINI_ARM_EXECUTE_UNIT_MACROS_SVH
`define MINI_ARM_EXECUTE_UNIT_MACROS_SVH
// Assert an implication on clk, disabled while reset is low.
`define MAEU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Assert an implication whose consequent is checked in the cycle after the antecedent.
`define MAEU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: rtl/maeu_pkg.sv
// Shared types and codes for the execute unit.
package maeu_pkg;
  localparam int unsigned IN_W  = 97;
  localparam int unsigned IN_BYTES_W = 104;
  localparam int unsigned OUT_W = 88;

  // Destination code that names no register.
  localparam logic [3:0] REG_NONE = 4'd12;

  typedef enum logic [3:0] {
    CMD_MOV = 4'd0, CMD_MVN = 4'd1, CMD_ADD = 4'd2, CMD_SUB = 4'd3,
    CMD_AND = 4'd4, CMD_ORR = 4'd5, CMD_EOR = 4'd6, CMD_LSL = 4'd7,
    CMD_LSR = 4'd8, CMD_LDR = 4'd9, CMD_STR = 4'd10, CMD_CMP = 4'd11,
    CMD_BEQ = 4'd12, CMD_NOP = 4'd13, CMD_R14 = 4'd14, CMD_R15 = 4'd15
  } cmd_t;

  typedef enum logic [2:0] {
    COND_AL = 3'd0, COND_EQ = 3'd1, COND_NE = 3'd2, COND_GT = 3'd3,
    COND_GE = 3'd4, COND_LT = 3'd5, COND_LE = 3'd6, COND_NV = 3'd7
  } cond_t;

  typedef enum logic [1:0] {
    KIND_REG = 2'd0, KIND_IMM = 2'd1, KIND_MEM = 2'd2, KIND_ZERO = 2'd3
  } kind_t;

  typedef struct packed {
    logic        jump_valid;
    logic [7:0]  jump_index;
    logic [31:0] second_imm;
    logic [3:0]  second_reg;
    logic [1:0]  second_kind;
    logic [31:0] first_imm;
    logic [3:0]  first_reg;
    logic [1:0]  first_kind;
    logic [3:0]  dest_reg;
    logic        set_flags;
    logic [2:0]  condition;
    logic [3:0]  command;
  } instr_t;

  typedef struct packed {
    logic [7:0]  branch_target;
    logic        branch_taken;
    logic [31:0] mem_write_value;
    logic [3:0]  mem_write_slot;
    logic        mem_write_enable;
    logic [3:0]  flags_nzcv;
    logic [31:0] reg_write_value;
    logic [3:0]  reg_write_index;
    logic        reg_write_enable;
    logic        executed;
  } result_t;

  function automatic logic cond_holds(input logic [2:0] c, input logic [3:0] f);
    logic n, z, v;
    begin
      n = f[3];
      z = f[2];
      v = f[0];
      case (cond_t'(c))
        COND_AL: cond_holds = 1'b1;
        COND_EQ: cond_holds = z;
        COND_NE: cond_holds = !z;
        COND_GT: cond_holds = !z && (n == v);
        COND_GE: cond_holds = (n == v);
        COND_LT: cond_holds = (n != v);
        COND_LE: cond_holds = z || (n != v);
        default: cond_holds = 1'b0;
      endcase
    end
  endfunction
endpackage

FILE: rtl/maeu_regfile.sv
// Register file: write port plus three reads, reset to zero.
module maeu_regfile #(
  parameter int unsigned NUM_REGS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        we,
  input  logic [3:0]  widx,
  input  logic [31:0] wdata,
  input  logic [3:0]  ra,
  input  logic [3:0]  rb,
  input  logic [3:0]  rc,
  output logic [31:0] da,
  output logic [31:0] db,
  output logic [31:0] dc
);
  logic [31:0] regs_r [NUM_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) regs_r[i] <= '0;
    end else if (we && (32'(widx) < NUM_REGS)) begin
      regs_r[widx] <= wdata;
    end
  end

  // Out-of-range indices read zero.
  always_comb begin
    da = '0;
    db = '0;
    dc = '0;
    for (int i = 0; i < NUM_REGS; i++) begin
      if (32'(ra) == i) da = regs_r[i];
      if (32'(rb) == i) db = regs_r[i];
      if (32'(rc) == i) dc = regs_r[i];
    end
  end
endmodule

FILE: rtl/maeu_dmem.sv
// Data memory with per-word valid bits; reads are registered.
module maeu_dmem #(
  parameter int unsigned MEM_WORDS = 16,
  parameter int unsigned AW = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] ra,
  input  logic [AW-1:0] rb,
  output logic [31:0]   qa,
  output logic [31:0]   qb
);
  logic [31:0]          mem_r [MEM_WORDS];
  logic [MEM_WORDS-1:0] vld_r;
  logic [31:0]          qa_r, qb_r;
  logic                 va_r, vb_r;

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    qa_r <= mem_r[ra];
    qb_r <= mem_r[rb];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      va_r  <= 1'b0;
      vb_r  <= 1'b0;
    end else begin
      if (we) vld_r[waddr] <= 1'b1;
      va_r <= vld_r[ra];
      vb_r <= vld_r[rb];
    end
  end

  assign qa = va_r ? qa_r : '0;
  assign qb = vb_r ? qb_r : '0;
endmodule

FILE: rtl/maeu_alu.sv
// Operation, flag and write-back decision for one instruction.
module maeu_alu (
  input  maeu_pkg::instr_t  ins,
  input  logic [3:0]        flags,
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  input  logic              a_mem_ok,
  input  logic [31:0]       store_val,
  input  logic [15:0]       slot,
  input  logic [15:0]       num_regs,
  input  logic [16:0]       prog_depth,
  output maeu_pkg::result_t res
);
  logic        ex;
  logic [31:0] r;
  logic [32:0] sum;
  logic [3:0]  fl;
  logic        rwe, dst_ok;

  assign dst_ok = (16'(ins.dest_reg) < num_regs) && (ins.dest_reg != maeu_pkg::REG_NONE);

  always_comb begin
    ex  = (ins.command <= maeu_pkg::CMD_BEQ) &&
          maeu_pkg::cond_holds(ins.condition, flags);
    r   = '0;
    fl  = flags;
    rwe = 1'b0;
    sum = '0;
    res = '0;
    if (ex) begin
      case (maeu_pkg::cmd_t'(ins.command))
        maeu_pkg::CMD_MOV, maeu_pkg::CMD_MVN: begin
          r = (ins.command == maeu_pkg::CMD_MVN) ? ~a : a;
          rwe = 1'b1;
          if (ins.set_flags) fl[3:2] = {r[31], r == '0};
        end
        maeu_pkg::CMD_ADD: begin
          sum = {1'b0, a} + {1'b0, b};
          r = sum[31:0];
          rwe = 1'b1;
          if (ins.set_flags)
            fl = {r[31], r == '0, sum[32], (~(a[31] ^ b[31])) & (a[31] ^ r[31])};
        end
        maeu_pkg::CMD_SUB, maeu_pkg::CMD_CMP: begin
          r = a - b;
          rwe = (ins.command == maeu_pkg::CMD_SUB);
          if (ins.set_flags || ins.command == maeu_pkg::CMD_CMP)
            fl = {r[31], r == '0, a >= b, (a[31] ^ b[31]) & (a[31] ^ r[31])};
        end
        maeu_pkg::CMD_AND, maeu_pkg::CMD_ORR, maeu_pkg::CMD_EOR: begin
          r = (ins.command == maeu_pkg::CMD_AND) ? (a & b) :
              (ins.command == maeu_pkg::CMD_ORR) ? (a | b) : (a ^ b);
          rwe = 1'b1;
          if (ins.set_flags) fl[3:2] = {r[31], r == '0};
        end
        maeu_pkg::CMD_LSL, maeu_pkg::CMD_LSR: begin
          if (ins.second_kind != maeu_pkg::KIND_IMM) r = a;
          else if (ins.second_imm >= 32'd32) r = '0;
          else r = (ins.command == maeu_pkg::CMD_LSL) ? (a << ins.second_imm[4:0])
                                                     : (a >> ins.second_imm[4:0]);
          rwe = 1'b1;
          if (ins.set_flags) fl[3:2] = {r[31], r == '0};
        end
        maeu_pkg::CMD_LDR: begin
          if (ins.first_kind == maeu_pkg::KIND_MEM && a_mem_ok) begin
            r = a;
            rwe = 1'b1;
          end
        end
        maeu_pkg::CMD_STR: begin
          if (ins.first_kind == maeu_pkg::KIND_MEM && a_mem_ok && dst_ok) begin
            res.mem_write_enable = 1'b1;
            res.mem_write_slot   = slot[3:0];
            res.mem_write_value  = store_val;
          end
        end
        maeu_pkg::CMD_BEQ: begin
          if (flags[2] && ins.jump_valid && (17'(ins.jump_index) < prog_depth)) begin
            res.branch_taken  = 1'b1;
            res.branch_target = ins.jump_index;
          end
        end
        default: ;
      endcase
    end
    res.executed = ex;
    res.flags_nzcv = fl;
    if (rwe && dst_ok) begin
      res.reg_write_enable = 1'b1;
      res.reg_write_index  = ins.dest_reg;
      res.reg_write_value  = r;
    end
  end
endmodule

FILE: rtl/mini_arm_execute_unit.sv
// Execute unit: two-stage read/execute over register file and data memory.
// An accepted instruction beat is registered in ins_r and executed; its result is
// registered in res_r, from which the result beat is offered.
// Throughput: one instruction per cycle; register and flag hazards forward,
// memory hazards forward the word written by the previous beat; a stalled
// result beat holds the whole pipe. Reset (rst_n low, synchronous):
// registers, flags and memory read as zero, memory_base returns to 0x100.
module mini_arm_execute_unit #(
  parameter int unsigned NUM_REGS      = 12,
  parameter int unsigned MEM_WORDS     = 16,
  parameter int unsigned PROGRAM_DEPTH = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // command, condition, set_flags, dest_reg, first_kind, first_reg, first_imm,
  // second_kind, second_reg, second_imm, jump_index, jump_valid; zero pad
  input  logic [103:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // executed, reg_write_enable, reg_write_index, reg_write_value, flags_nzcv,
  // mem_write_enable, mem_write_slot, mem_write_value, branch_taken,
  // branch_target
  output logic [87:0]  out_tdata
);
  localparam int unsigned AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

  logic [31:0] base_r;
  logic [3:0]  flags_r;
  maeu_pkg::instr_t  ins_r;
  logic        v1_r, v2_r;
  maeu_pkg::result_t res, res_r;
  logic        adv;

  // Stage 1 sees addresses; stage 2 executes with memory data.
  maeu_pkg::instr_t ins_in;
  assign ins_in = maeu_pkg::instr_t'(in_tdata[maeu_pkg::IN_W-1:0]);

  assign adv = !v2_r || out_tready;
  assign in_tready = adv;
  assign out_tvalid = v2_r;
  assign out_tdata  = res_r;

  // Register reads happen in execute stage; regfile writes are visible next cycle.
  logic [31:0] ra_d, rb_d, rc_d, ra_f, rb_f, rc_f;
  logic [31:0] pa_d, pb_d;
  logic        x_fire;
  assign x_fire = v1_r && adv;

  maeu_regfile #(.NUM_REGS(NUM_REGS)) u_rf (
    .clk(clk), .rst_n(rst_n),
    .we(x_fire && res.reg_write_enable), .widx(res.reg_write_index),
    .wdata(res.reg_write_value),
    .ra(ins_r.first_reg), .rb(ins_r.second_reg), .rc(ins_r.dest_reg),
    .da(ra_d), .db(rb_d), .dc(rc_d)
  );
  assign ra_f = ra_d;
  assign rb_f = rb_d;
  assign rc_f = rc_d;

  // Address check on register value; memory is read in stage 1 using a
  // peek at the register file with forwarding from stage 2.
  logic [31:0] pre_a, pre_b;
  logic [3:0]  fidx_a, fidx_b;
  maeu_regfile #(.NUM_REGS(NUM_REGS)) u_rf_shadow (
    .clk(clk), .rst_n(rst_n),
    .we(x_fire && res.reg_write_enable), .widx(res.reg_write_index),
    .wdata(res.reg_write_value),
    .ra(ins_in.first_reg), .rb(ins_in.second_reg), .rc(4'd0),
    .da(pa_d), .db(pb_d), .dc()
  );
  assign fidx_a = ins_in.first_reg;
  assign fidx_b = ins_in.second_reg;
  always_comb begin
    pre_a = pa_d;
    pre_b = pb_d;
    if (x_fire && res.reg_write_enable && res.reg_write_index == fidx_a)
      pre_a = res.reg_write_value;
    if (x_fire && res.reg_write_enable && res.reg_write_index == fidx_b)
      pre_b = res.reg_write_value;
  end

  function automatic logic [AW:0] slot_of(input logic [31:0] addr,
                                          input logic [31:0] base);
    logic [31:0] off;
    begin
      off = addr - base;
      if (addr < base || off[1:0] != 2'b00 || (off >> 2) >= 32'(MEM_WORDS))
        slot_of = '0;
      else
        slot_of = {1'b1, off[AW+1:2]};
    end
  endfunction

  logic [AW:0] sa_in, sb_in, sa_r, sb_r, sa_x, sb_x;
  assign sa_in = slot_of(pre_a, base_r);
  assign sb_in = slot_of(pre_b, base_r);
  assign sa_x = slot_of(ra_f, base_r);
  assign sb_x = slot_of(rb_f, base_r);

  logic [31:0] qa, qb;
  maeu_dmem #(.MEM_WORDS(MEM_WORDS), .AW(AW)) u_mem (
    .clk(clk), .rst_n(rst_n),
    .we(x_fire && res.mem_write_enable), .waddr(sa_x[AW-1:0]),
    .wdata(res.mem_write_value),
    .ra(adv ? sa_in[AW-1:0] : sa_r[AW-1:0]),
    .rb(adv ? sb_in[AW-1:0] : sb_r[AW-1:0]),
    .qa(qa), .qb(qb)
  );

  // Forward a store made in the same cycle the word was read.
  logic        fw_a_r, fw_b_r;
  logic [31:0] fw_val_r;
  logic [31:0] ma, mb, a, b;
  assign ma = fw_a_r ? fw_val_r : qa;
  assign mb = fw_b_r ? fw_val_r : qb;

  always_comb begin
    case (maeu_pkg::kind_t'(ins_r.first_kind))
      maeu_pkg::KIND_REG:  a = ra_f;
      maeu_pkg::KIND_IMM:  a = ins_r.first_imm;
      maeu_pkg::KIND_MEM:  a = sa_x[AW] ? ma : '0;
      default:             a = '0;
    endcase
    case (maeu_pkg::kind_t'(ins_r.second_kind))
      maeu_pkg::KIND_REG:  b = rb_f;
      maeu_pkg::KIND_IMM:  b = ins_r.second_imm;
      maeu_pkg::KIND_MEM:  b = sb_x[AW] ? mb : '0;
      default:             b = '0;
    endcase
  end

  maeu_alu u_alu (
    .ins(ins_r), .flags(flags_r), .a(a), .b(b), .a_mem_ok(sa_x[AW]),
    .store_val(rc_f), .slot(16'(sa_x[AW-1:0])), .num_regs(16'(NUM_REGS)),
    .prog_depth(17'(PROGRAM_DEPTH)), .res(res)
  );

  logic [AW:0] sel_a, sel_b;
  assign sel_a = adv ? sa_in : sa_r;
  assign sel_b = adv ? sb_in : sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= 32'h100;
      flags_r <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      fw_a_r  <= 1'b0;
      fw_b_r  <= 1'b0;
    end else begin
      if (cfg_we) base_r <= cfg_wdata;
      if (adv) begin
        v1_r <= in_tvalid;
        v2_r <= v1_r;
        if (v1_r) flags_r <= res.flags_nzcv;
      end
      // Hold forwarding while stalled; refresh when a store lands.
      fw_a_r <= (x_fire && res.mem_write_enable && sel_a[AW] &&
                 sel_a[AW-1:0] == sa_x[AW-1:0]) || (!adv && fw_a_r && !x_fire);
      fw_b_r <= (x_fire && res.mem_write_enable && sel_b[AW] &&
                 sel_b[AW-1:0] == sa_x[AW-1:0]) || (!adv && fw_b_r && !x_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (x_fire && res.mem_write_enable) fw_val_r <= res.mem_write_value;
    if (adv) begin
      ins_r <= ins_in;
      sa_r  <= sa_in;
      sb_r  <= sb_in;
      res_r <= res;
    end
  end
endmodule

FILE: rtl/maeu_checker.sv
// Port-level checker for the execute unit, bound to the top level.
`include "mini_arm_execute_unit_macros.svh"
module maeu_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [87:0]  out_tdata
);
  `MAEU_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result beat dropped while stalled")
  `MAEU_ASSERT_IMP(a_ready_free, !out_tvalid, in_tready, "input stalled with empty output")
  `MAEU_ASSERT_IMP(a_we_exec, out_tvalid && (out_tdata[1] || out_tdata[42] || out_tdata[79]), out_tdata[0], "write without execute")
  `MAEU_ASSERT_IMP(a_one_kind, out_tvalid, !(out_tdata[1] && out_tdata[42]), "register and memory write together")
endmodule

bind mini_arm_execute_unit maeu_checker u_maeu_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
